### rtl/ctl_pkg.sv
// Shared types, character codes and byte classifiers for the command token lexer.
// No dependencies; every other file of the lexer imports this package.
package ctl_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int FIELD_BITS = 16;
  localparam int BATCH_MAX = 3;

  typedef enum logic [2:0] {
    KIND_END      = 3'd0,
    KIND_BEGIN    = 3'd1,
    KIND_END_NEST = 3'd2,
    KIND_NAME     = 3'd3,
    KIND_NUMBER   = 3'd4,
    KIND_KEYWORD  = 3'd5,
    KIND_ERROR    = 3'd6,
    KIND_DONE     = 3'd7
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_NAME        = 3'd1,
    MODE_NAME_SKIP   = 3'd2,
    MODE_NUMBER      = 3'd3,
    MODE_NUMBER_SKIP = 3'd4,
    MODE_KEYWORD     = 3'd5
  } scan_mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // One result as it travels from the step logic to the output port.
  typedef struct packed {
    token_kind_t           kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] consumed;
    logic                  in_token;
    logic                  run_end;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_kw_char(input logic [7:0] c);
    return (c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]}) ||
           (c inside {CH_BANG, CH_QMARK, CH_MINUS, CH_STAR, CH_PLUS, CH_SLASH});
  endfunction

  function automatic logic is_terminator(input logic [7:0] c);
    return c inside {CH_NUL, CH_SPACE, CH_LF, CH_CLOSE};
  endfunction

endpackage

### rtl/ctl_step.sv
// Combinational next-state and result logic for one byte of the lexer.
// Depends on ctl_pkg for the mode and kind codes, classifiers and result type.
module ctl_step #(
  parameter int OFFSET_BITS = ctl_pkg::OFFSET_BITS_DEF
) (
  input  ctl_pkg::scan_mode_t   mode,
  input  logic [OFFSET_BITS-1:0] pos,
  input  logic [OFFSET_BITS-1:0] origin,
  input  logic [7:0]             data_byte,
  input  logic                   final_byte,
  output ctl_pkg::scan_mode_t   mode_next,
  output logic [OFFSET_BITS-1:0] pos_next,
  output logic [OFFSET_BITS-1:0] origin_next,
  output ctl_pkg::result_t       batch [ctl_pkg::BATCH_MAX],
  output logic [1:0]             batch_count
);
  import ctl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  function automatic logic [FIELD_BITS-1:0] clip(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FIELD_BITS-1:0] e;
    e = {{FIELD_BITS{1'b0}}, v};
    return (e[OFFSET_BITS+FIELD_BITS-1:FIELD_BITS] != '0) ? '1 : e[FIELD_BITS-1:0];
  endfunction

  function automatic result_t make_res(input token_kind_t k,
                                       input logic [OFFSET_BITS-1:0] s,
                                       input logic [OFFSET_BITS-1:0] l,
                                       input logic [OFFSET_BITS-1:0] cons,
                                       input logic ins);
    result_t r;
    r.kind     = k;
    r.start    = clip(s);
    r.length   = clip(l);
    r.consumed = clip(cons);
    r.in_token = ins;
    r.run_end  = 1'b0;
    return r;
  endfunction

  scan_mode_t             mode_tok;
  logic [OFFSET_BITS-1:0] origin_tok;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] name_start;
  logic                   do_top;
  logic                   have_a, have_b;
  result_t                res_a, res_b, res_c;
  logic [1:0]             n;

  always_comb begin
    mode_tok   = mode;
    origin_tok = origin;
    do_top     = 1'b0;
    have_a     = 1'b0;
    have_b     = 1'b0;
    res_a      = make_res(KIND_ERROR, origin, '0, '0, 1'b0);
    res_b      = make_res(KIND_ERROR, pos, '0, '0, 1'b0);
    name_start = (origin == POS_MAX) ? POS_MAX : origin + OFFSET_BITS'(1);

    case (mode)
      MODE_NAME: begin
        if (data_byte inside {CH_NUL, CH_LF, CH_CR, CH_VT, CH_FF}) begin
          mode_tok = MODE_NAME_SKIP;
        end else if (data_byte == CH_QUOTE) begin
          have_a   = 1'b1;
          res_a    = make_res(KIND_NAME, name_start,
                              (pos >= name_start) ? pos - name_start : '0, '0, 1'b0);
          mode_tok = MODE_IDLE;
        end
      end
      MODE_NAME_SKIP: begin
        if (data_byte == CH_QUOTE) begin
          have_a   = 1'b1;
          mode_tok = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_terminator(data_byte)) begin
          have_a   = 1'b1;
          res_a    = make_res(KIND_NUMBER, origin, pos - origin, '0, 1'b0);
          mode_tok = MODE_IDLE;
          do_top   = 1'b1;
        end else if (!is_digit(data_byte)) begin
          mode_tok = MODE_NUMBER_SKIP;
        end
      end
      MODE_NUMBER_SKIP: begin
        if (data_byte inside {CH_NUL, CH_LF, CH_CLOSE}) begin
          have_a   = 1'b1;
          mode_tok = MODE_IDLE;
          do_top   = 1'b1;
        end
      end
      MODE_KEYWORD: begin
        if (is_terminator(data_byte)) begin
          have_a   = 1'b1;
          res_a    = make_res(KIND_KEYWORD, origin, pos - origin, '0, 1'b0);
          mode_tok = MODE_IDLE;
          do_top   = 1'b1;
        end else if (!is_kw_char(data_byte) && !is_digit(data_byte)) begin
          have_a   = 1'b1;
          mode_tok = MODE_IDLE;
          do_top   = 1'b1;
        end
      end
      default: begin
        mode_tok = MODE_IDLE;
        do_top   = 1'b1;
      end
    endcase

    // Top-level handling of a fresh byte or a terminator that ended a token.
    if (do_top) begin
      if (data_byte inside {CH_SPACE, CH_CR, CH_TAB}) begin
        have_b = 1'b0;
      end else if (data_byte == CH_LF) begin
        have_b = 1'b1;
        res_b  = make_res(KIND_END, pos, OFFSET_BITS'(1), '0, 1'b0);
      end else if (data_byte == CH_OPEN) begin
        have_b = 1'b1;
        res_b  = make_res(KIND_BEGIN, pos, OFFSET_BITS'(1), '0, 1'b0);
      end else if (data_byte == CH_CLOSE) begin
        have_b = 1'b1;
        res_b  = make_res(KIND_END_NEST, pos, OFFSET_BITS'(1), '0, 1'b0);
      end else if (data_byte == CH_QUOTE) begin
        mode_tok   = MODE_NAME;
        origin_tok = pos;
      end else if (is_digit(data_byte)) begin
        mode_tok   = MODE_NUMBER;
        origin_tok = pos;
      end else if (is_kw_char(data_byte)) begin
        mode_tok   = MODE_KEYWORD;
        origin_tok = pos;
      end else begin
        have_b = 1'b1;
      end
    end

    pos_inc = (pos == POS_MAX) ? pos : pos + OFFSET_BITS'(1);

    // The end-of-input summary, after which everything starts over.
    if (mode_tok != MODE_IDLE) begin
      res_c = make_res(KIND_DONE, '0, '0, origin_tok, 1'b1);
    end else begin
      res_c = make_res(KIND_DONE, '0, '0, pos_inc, 1'b0);
    end

    if (final_byte) begin
      mode_next   = MODE_IDLE;
      pos_next    = '0;
      origin_next = '0;
    end else begin
      mode_next   = mode_tok;
      pos_next    = pos_inc;
      origin_next = origin_tok;
    end

    // Pack the results in order and flag the last one of the byte.
    n        = 2'd0;
    batch[0] = res_a;
    batch[1] = res_b;
    batch[2] = res_c;
    if (have_a) begin
      batch[n] = res_a;
      n        = n + 2'd1;
    end
    if (have_b) begin
      batch[n] = res_b;
      n        = n + 2'd1;
    end
    if (final_byte) begin
      batch[n] = res_c;
      n        = n + 2'd1;
    end
    if (n != 2'd0) begin
      batch[n - 2'd1].run_end = 1'b1;
    end
    batch_count = n;
  end

endmodule

### rtl/ctl_queue.sv
// Result queue of the lexer: takes a batch of up to three results at once and
// hands them out one per cycle while pop is asserted. Depends on ctl_pkg for the result type.
module ctl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ctl_pkg::result_t   batch [ctl_pkg::BATCH_MAX],
  input  logic [1:0]         batch_count,
  input  logic               pop,
  output ctl_pkg::result_t   head,
  output logic               head_valid,
  output logic               can_load
);
  import ctl_pkg::*;

  localparam int DEPTH = BATCH_MAX + 1;

  result_t    slots [DEPTH];
  result_t    slots_next [DEPTH];
  logic [2:0] count;
  logic [2:0] count_next;
  logic [2:0] base;
  logic [2:0] k;

  // Room for a full batch remains once at most one result is left.
  assign base       = count - {2'b00, pop};
  assign can_load   = (base <= 3'd1);
  assign head       = slots[0];
  assign head_valid = (count != 3'd0);

  always_comb begin
    k = 3'd0;
    for (int j = 0; j < DEPTH; j++) begin
      if (pop && j < DEPTH - 1) begin
        slots_next[j] = slots[j + 1];
      end else begin
        slots_next[j] = slots[j];
      end
      k = 3'(j) - base;
      if (load && 3'(j) >= base && k < {1'b0, batch_count}) begin
        slots_next[j] = batch[k[1:0]];
      end
    end
    count_next = base + (load ? {1'b0, batch_count} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      slots[j] <= slots_next[j];
    end
  end

endmodule

### rtl/command_token_lexer_core.sv
// A request's results are registered in the result queue before they reach the outputs.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall is
// low; the output port hands out one result per cycle, so a byte with two or three results
// holds it longer. The four-entry result queue sets that figure: a new byte is taken whenever
// at most one result will remain queued after this cycle.
// Reset (rst, synchronous): scan mode goes idle, offsets clear, the result queue empties.
module command_token_lexer_core #(
  parameter int OFFSET_BITS = ctl_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] consumed_count,
  output logic        ended_inside_token,
  output logic        run_end
);
  import ctl_pkg::*;

  // Lexer state: what kind of token is open, where the next byte sits and
  // where the open token began.
  scan_mode_t             mode;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] origin;

  scan_mode_t             mode_next;
  logic [OFFSET_BITS-1:0] pos_next;
  logic [OFFSET_BITS-1:0] origin_next;

  result_t    batch [BATCH_MAX];
  logic [1:0] batch_count;
  result_t    head;
  logic       head_valid;
  logic       can_load;
  logic       accept;
  logic       pop;

  // A request is taken whenever the queue has room for everything it could
  // produce, even while a result is still waiting downstream.
  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;
  assign pop      = head_valid && !out_stall;

  // The whole per-byte decision is a single combinational pass.
  ctl_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .mode       (mode),
    .pos        (pos),
    .origin     (origin),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .mode_next  (mode_next),
    .pos_next   (pos_next),
    .origin_next(origin_next),
    .batch      (batch),
    .batch_count(batch_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      origin <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      origin <= origin_next;
    end
  end

  // Results are registered here and drained one per cycle while out_stall is low.
  ctl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .batch      (batch),
    .batch_count(batch_count),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .can_load   (can_load)
  );

  assign out_valid          = head_valid;
  assign token_kind         = head.kind;
  assign token_start        = head.start;
  assign token_length       = head.length;
  assign consumed_count     = head.consumed;
  assign ended_inside_token = head.in_token;
  assign run_end            = head.run_end;

endmodule

### rtl/ctl_checker.sv
// Port-level checks for the command token lexer, bound to its top level.
// Depends on ctl_pkg for the token kind codes.
module ctl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  token_kind,
  input logic [15:0] token_start,
  input logic [15:0] token_length,
  input logic [15:0] consumed_count,
  input logic        ended_inside_token,
  input logic        run_end
);
  import ctl_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_DONE |-> token_start == 16'd0 &&
    token_length == 16'd0 && run_end)
    else $error("done result malformed");

  a_token_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_DONE |-> consumed_count == 16'd0 &&
    !ended_inside_token)
    else $error("token result carries a done summary");

endmodule

bind command_token_lexer_core ctl_checker u_ctl_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .token_kind        (token_kind),
  .token_start       (token_start),
  .token_length      (token_length),
  .consumed_count    (consumed_count),
  .ended_inside_token(ended_inside_token),
  .run_end           (run_end)
);
